### hdl/fcpm_pkg.sv
// Package for the false-color pixel mapper: widths, register map, sine ROM
// and small arithmetic helpers. No dependencies.
`default_nettype none

package fcpm_pkg;

    // Gray-level count is 1 << LEVEL_W; the level port is LEVEL_W bits wide.
    localparam int LEVEL_W    = 8;
    localparam int HUE_W      = 19;           // hue6 in Q3.16
    localparam int FRAC_W     = 16;
    localparam int PHASE_W    = 10;           // sine phase, fraction of a turn
    localparam int HUE_SHIFT  = FRAC_W - LEVEL_W;
    localparam int PHASE_SHIFT = PHASE_W - LEVEL_W;
    localparam int SINE_W     = 17;           // Q0.16 with room for 1.0
    // entries 0..255; the quarter-turn point (1.0) is handled outside the table
    localparam int SINE_ENTRIES = 256;
    localparam int ROM_IDX_W  = 9;
    localparam logic [23:0] DEN_SF = 24'd16711680;  // 255 * 65536
    localparam logic [16:0] FULL_Q16 = 17'd65536;

    // Register indexes (byte address = 4 * index).
    typedef enum logic [1:0] {
        REG_MAP_STYLE    = 2'd0,
        REG_CONTOUR_STEP = 2'd1,
        REG_SATURATION   = 2'd2,
        REG_BRIGHTNESS   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        STYLE_RAINBOW = 2'd0,
        STYLE_CONTOUR = 2'd1,
        STYLE_SINE    = 2'd2,
        STYLE_SPARE   = 2'd3
    } map_style_t;

    typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] sine_rom_t;

    // Quarter-wave |sin| entry k, Q0.16, from a Q2.30 Taylor series.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned u;
        longint unsigned one;
        one = 64'd1 << 30;
        x  = (64'd1686629713 * longint'(k)) >> 8;
        x2 = (x * x) >> 30;
        t  = one;
        t  = one - ((x2 * t) >> 30) / 110;
        t  = one - ((x2 * t) >> 30) / 72;
        t  = one - ((x2 * t) >> 30) / 42;
        t  = one - ((x2 * t) >> 30) / 20;
        t  = one - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        u  = (s + 64'd8192) >> 14;
        if (u > 64'd65536) begin
            u = 64'd65536;
        end
        return u[SINE_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            rom[i] = quarter_sine(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // One restoring step of level mod step: shift in one bit, subtract.
    function automatic logic [7:0] rem_step(input logic [7:0] rem, input logic b,
                                            input logic [7:0] step);
        logic [8:0] t;
        t = {rem, b};
        if (t >= {1'b0, step}) begin
            t = t - {1'b0, step};
        end
        return t[7:0];
    endfunction

    // floor(x / 255) for x <= 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

### hdl/false_color_pixel_mapper_core.sv
// False-color pixel mapper: gray level to RGB through fixed-point HSV to RGB.
// Depends on fcpm_pkg (widths, register map, sine ROM, helpers).
//
// Usage
//   Input channel  s_valid/s_ready/s_level: one gray level per beat.
//   Output channel m_valid/m_ready/m_red/m_green/m_blue: one color per beat.
//   APB-style register port: map_style @0x0, contour_step @0x4, saturation @0x8,
//   brightness @0xC. pready is tied high; writes land on the access cycle. The
//   user must change registers only while no pixel is in flight (not enforced).
// Throughput and depth
//   Seven register stages, the last being the output register. One pixel per
//   clock sustained while m_ready is high. The depth is set by the contour
//   remainder (two restoring steps per stage over four stages) followed by
//   the multiply chain (sat*f, then brightness * factor, then /255).
// Stalls
//   Each stage holds when it is full and the stage after it is held, so
//   bubbles close up while m_ready is low; s_ready only drops once every
//   stage is full and the output beat is waiting.
// Reset
//   aresetn (sync, active low) empties the pipeline and loads the register
//   defaults: rainbow, contour step 16, saturation and brightness 255.
`default_nettype none

module false_color_pixel_mapper_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // pixel in
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_level,
    // color out
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0] map_style_reg;
    logic [7:0] contour_step_reg;
    logic [7:0] saturation_reg;
    logic [7:0] brightness_reg;
    logic       cfg_wr;
    fcpm_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = fcpm_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_style_reg    <= fcpm_pkg::STYLE_RAINBOW;
            contour_step_reg <= 8'd16;
            saturation_reg   <= 8'd255;
            brightness_reg   <= 8'd255;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                fcpm_pkg::REG_MAP_STYLE: begin
                    map_style_reg <= pwdata[1:0];
                end
                fcpm_pkg::REG_CONTOUR_STEP: begin
                    // a zero step is stored as one
                    contour_step_reg <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
                end
                fcpm_pkg::REG_SATURATION: begin
                    saturation_reg <= pwdata[7:0];
                end
                default: begin
                    brightness_reg <= pwdata[7:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            fcpm_pkg::REG_MAP_STYLE:    prdata = {30'd0, map_style_reg};
            fcpm_pkg::REG_CONTOUR_STEP: prdata = {24'd0, contour_step_reg};
            fcpm_pkg::REG_SATURATION:   prdata = {24'd0, saturation_reg};
            default:                    prdata = {24'd0, brightness_reg};
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when empty or when its successor moves
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic en1, en2, en3, en4, en5, en6, en7;

    assign en7 = !v7_reg || m_ready;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready = en1;
    assign m_valid = v7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-4: level mod contour_step, two restoring steps per stage.
    // Stage 2 also reads the sine ROM and forms the sine hue.
    // ------------------------------------------------------------------
    logic [7:0] lvl1_reg, lvl2_reg, lvl3_reg;
    logic [7:0] rem1_reg, rem2_reg, rem3_reg;
    logic [7:0] rem1_next, rem2_next, rem3_next, rem4;
    logic [fcpm_pkg::HUE_W-1:0] hue_sin2_reg, hue_sin3_reg;
    logic [fcpm_pkg::HUE_W-1:0] hue_sin2_next;

    logic [fcpm_pkg::PHASE_W-1:0]   phase1;
    logic [7:0]                     quad_pos1;
    logic [fcpm_pkg::ROM_IDX_W-1:0] rom_idx1;
    logic [fcpm_pkg::SINE_W-1:0]    sine1;

    assign rem1_next = fcpm_pkg::rem_step(fcpm_pkg::rem_step(8'd0, s_level[7], contour_step_reg),
                                          s_level[6], contour_step_reg);
    assign rem2_next = fcpm_pkg::rem_step(fcpm_pkg::rem_step(rem1_reg, lvl1_reg[5],
                                                             contour_step_reg),
                                          lvl1_reg[4], contour_step_reg);
    assign rem3_next = fcpm_pkg::rem_step(fcpm_pkg::rem_step(rem2_reg, lvl2_reg[3],
                                                             contour_step_reg),
                                          lvl2_reg[2], contour_step_reg);
    assign rem4      = fcpm_pkg::rem_step(fcpm_pkg::rem_step(rem3_reg, lvl3_reg[1],
                                                             contour_step_reg),
                                          lvl3_reg[0], contour_step_reg);

    // phase in 1/1024 turn; odd quadrants mirror the quarter wave
    assign phase1    = fcpm_pkg::PHASE_W'(lvl1_reg) << fcpm_pkg::PHASE_SHIFT;
    assign quad_pos1 = phase1[7:0];
    assign rom_idx1  = phase1[8] ? (9'd256 - {1'b0, quad_pos1}) : {1'b0, quad_pos1};
    // the quarter-turn point itself is exactly 1.0
    assign sine1     = rom_idx1[8] ? fcpm_pkg::FULL_Q16 : fcpm_pkg::SINE_ROM[rom_idx1[7:0]];
    // |sin| * 6 as two shifted adds
    assign hue_sin2_next = {sine1, 2'b00} + {1'b0, sine1, 1'b0};

    always_ff @(posedge aclk) begin
        if (en1) begin
            lvl1_reg <= s_level;
            rem1_reg <= rem1_next;
        end
        if (en2) begin
            lvl2_reg     <= lvl1_reg;
            rem2_reg     <= rem2_next;
            hue_sin2_reg <= hue_sin2_next;
        end
        if (en3) begin
            lvl3_reg     <= lvl2_reg;
            rem3_reg     <= rem3_next;
            hue_sin3_reg <= hue_sin2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pick the hue, split into sector and fraction
    // ------------------------------------------------------------------
    logic        use_rainbow;
    logic [10:0] lvl_x6;
    logic [fcpm_pkg::HUE_W-1:0] hue_rb, hue6;
    logic [2:0]  sector4_next;
    logic [15:0] frac4_next;
    logic [2:0]  sector4_reg, sector5_reg, sector6_reg;
    logic [15:0] frac4_reg;

    always_comb begin
        unique case (fcpm_pkg::map_style_t'(map_style_reg))
            fcpm_pkg::STYLE_SINE:    use_rainbow = 1'b0;
            fcpm_pkg::STYLE_CONTOUR: use_rainbow = (rem4 == 8'd0);
            default:                 use_rainbow = 1'b1;
        endcase
    end

    assign lvl_x6 = {1'b0, lvl3_reg, 2'b00} + {2'b00, lvl3_reg, 1'b0};
    assign hue_rb = fcpm_pkg::HUE_W'(lvl_x6) << fcpm_pkg::HUE_SHIFT;
    assign hue6   = use_rainbow ? hue_rb : hue_sin3_reg;

    always_comb begin
        sector4_next = hue6[18:16];
        frac4_next   = hue6[15:0];
        // hue of a full turn wraps to red
        if (sector4_next >= 3'd6) begin
            sector4_next = 3'd0;
            frac4_next   = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            sector4_reg <= sector4_next;
            frac4_reg   <= frac4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: saturation products
    // ------------------------------------------------------------------
    logic [23:0] sat_f, sat_inv_f;
    logic [23:0] a2_reg, a3_reg;
    logic [15:0] y1_5_reg, y1_6_reg;
    logic [16:0] inv_f;

    assign inv_f     = fcpm_pkg::FULL_Q16 - {1'b0, frac4_reg};
    assign sat_f     = saturation_reg * frac4_reg;
    assign sat_inv_f = 24'(saturation_reg * inv_f);

    always_ff @(posedge aclk) begin
        if (en5) begin
            sector5_reg <= sector4_reg;
            a2_reg      <= fcpm_pkg::DEN_SF - sat_f;
            a3_reg      <= fcpm_pkg::DEN_SF - sat_inv_f;
            y1_5_reg    <= brightness_reg * (8'd255 - saturation_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: brightness times factor, keep the /65536 part
    // ------------------------------------------------------------------
    logic [31:0] prod2, prod3;
    logic [15:0] y2_reg, y3_reg;

    assign prod2 = brightness_reg * a2_reg;
    assign prod3 = brightness_reg * a3_reg;

    always_ff @(posedge aclk) begin
        if (en6) begin
            sector6_reg <= sector5_reg;
            y1_6_reg    <= y1_5_reg;
            y2_reg      <= prod2[31:16];
            y3_reg      <= prod3[31:16];
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: /255 and sector routing into the output register
    // ------------------------------------------------------------------
    logic [7:0] p1, p2, p3;
    logic [7:0] red_next, green_next, blue_next;
    logic [7:0] red_reg, green_reg, blue_reg;

    assign p1 = fcpm_pkg::div255(y1_6_reg);
    assign p2 = fcpm_pkg::div255(y2_reg);
    assign p3 = fcpm_pkg::div255(y3_reg);

    always_comb begin
        unique case (sector6_reg)
            3'd0: begin
                red_next = brightness_reg; green_next = p3; blue_next = p1;
            end
            3'd1: begin
                red_next = p2; green_next = brightness_reg; blue_next = p1;
            end
            3'd2: begin
                red_next = p1; green_next = brightness_reg; blue_next = p3;
            end
            3'd3: begin
                red_next = p1; green_next = p2; blue_next = brightness_reg;
            end
            3'd4: begin
                red_next = p3; green_next = p1; blue_next = brightness_reg;
            end
            default: begin
                red_next = brightness_reg; green_next = p1; blue_next = p2;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en7) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

endmodule

`default_nettype wire

### hdl/fcpm_checker.sv
// Port-level checker for false_color_pixel_mapper_core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module fcpm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_red,
    input wire logic [7:0]  m_green,
    input wire logic [7:0]  m_blue,
    input wire logic        pready
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output beat present after reset");

    // a waiting output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
                                && $stable(m_blue))
        else $error("output beat changed while stalled");

    // input backpressure only when the output beat is stuck
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("s_ready low with output free");

    // an empty output register never blocks the input
    a_no_early_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty output");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind false_color_pixel_mapper_core fcpm_checker u_fcpm_checker (.*);

`default_nettype wire
